### rtl/tis_pkg.sv
// tis_pkg: shared constants for the triangle isoline segment block
// no dependencies
`timescale 1ns / 1ps
package tis_pkg;
  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned FracTBitsDef  = 24;
endpackage

### rtl/tis_cross.sv
// tis_cross: pipelined crossing point of one edge, restoring divider then lerp
// depends on tis_pkg
`timescale 1ns / 1ps
module tis_cross #(
  parameter int unsigned CW = tis_pkg::CoordWidthDef,
  parameter int unsigned TB = tis_pkg::FracTBitsDef
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] pa_x_i,
  input  logic signed [CW-1:0] pa_y_i,
  input  logic signed [CW-1:0] pb_x_i,
  input  logic signed [CW-1:0] pb_y_i,
  input  logic        [CW:0]   num_i,
  input  logic        [CW:0]   den_i,
  output logic signed [CW-1:0] px_o,
  output logic signed [CW-1:0] py_o
);
  import tis_pkg::*;
  localparam int unsigned NS = TB + 1;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned PW = DW + TB + 1;

  logic        [DW:0]   rem_q [NS+1];
  logic        [DW-1:0] den_q [NS+1];
  logic        [TB:0]   quo_q [NS+1];
  logic signed [CW-1:0] ax_q [NS+1], ay_q [NS+1], bx_q [NS+1], by_q [NS+1];

  always_comb begin
    rem_q[0] = {1'b0, num_i};
    den_q[0] = den_i;
    quo_q[0] = '0;
    ax_q[0] = pa_x_i; ay_q[0] = pa_y_i; bx_q[0] = pb_x_i; by_q[0] = pb_y_i;
  end

  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [DW:0] r_sh;
    logic        ge;
    assign r_sh = (s == 0) ? rem_q[s] : {rem_q[s][DW-1:0], 1'b0};
    assign ge   = r_sh >= {1'b0, den_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge ? r_sh - {1'b0, den_q[s]} : r_sh;
        quo_q[s+1] <= {quo_q[s][TB-1:0], ge};
        den_q[s+1] <= den_q[s];
        ax_q[s+1] <= ax_q[s]; ay_q[s+1] <= ay_q[s];
        bx_q[s+1] <= bx_q[s]; by_q[s+1] <= by_q[s];
      end
    end
  end

  logic signed [DW-1:0] dx_q, dy_q;
  logic        [TB:0]   t_q;
  logic signed [CW-1:0] ax2_q, ay2_q, ax3_q, ay3_q;
  logic signed [PW-1:0] mx_q, my_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q  <= DW'(bx_q[NS]) - DW'(ax_q[NS]);
      dy_q  <= DW'(by_q[NS]) - DW'(ay_q[NS]);
      t_q   <= quo_q[NS];
      ax2_q <= ax_q[NS];
      ay2_q <= ay_q[NS];
      mx_q  <= PW'(dx_q) * $signed({1'b0, t_q});
      my_q  <= PW'(dy_q) * $signed({1'b0, t_q});
      ax3_q <= ax2_q;
      ay3_q <= ay2_q;
      px_o  <= ax3_q + CW'(mx_q >>> TB);
      py_o  <= ay3_q + CW'(my_q >>> TB);
    end
  end
endmodule

### rtl/triangle_isoline_segment.sv
// triangle_isoline_segment: marching-triangles isoline segment extraction
// depends on tis_pkg and tis_cross
//
// one triangle and a contour level enter per request on the input channel
// (in_valid_i / in_stall_o); at most one segment leaves per request on the
// output channel (out_valid_o / out_stall_i). triangles with no crossing or
// with z_invalid_i set give no segment.
// the block is a pipeline of FRAC_T_BITS + 5 register stages: one for the
// classify, FRAC_T_BITS + 1 for the restoring divider steps of t, one for the
// lerp differences, one for the multiply, one for the add into the output
// register. throughput is one triangle per cycle while the output is not stalled.
// a stall at the output freezes the whole pipeline; in_stall_o follows the
// output stall only when the output register holds a segment.
// reset clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
module triangle_isoline_segment #(
  parameter int unsigned COORD_WIDTH = tis_pkg::CoordWidthDef,
  parameter int unsigned FRAC_T_BITS = tis_pkg::FracTBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_z_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_z_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_z_i,
  input  logic signed [COORD_WIDTH-1:0] contour_level_i,
  input  logic                          z_invalid_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] seg_start_x_o,
  output logic signed [COORD_WIDTH-1:0] seg_start_y_o,
  output logic signed [COORD_WIDTH-1:0] seg_end_x_o,
  output logic signed [COORD_WIDTH-1:0] seg_end_y_o
);
  import tis_pkg::*;
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned LAT = FRAC_T_BITS + 5;

  logic en;
  logic [LAT-1:0] vld_q;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // classify and pick the two crossing edges
  logic ab_a, ab_b, ab_c, hit;
  logic x01, x12;
  assign ab_a = vertex_a_z_i >= contour_level_i;
  assign ab_b = vertex_b_z_i >= contour_level_i;
  assign ab_c = vertex_c_z_i >= contour_level_i;
  assign x01 = ab_a != ab_b;
  assign x12 = ab_b != ab_c;
  assign hit = !z_invalid_i && (x01 || x12);

  logic signed [CW-1:0] p0x_d, p0y_d, q0x_d, q0y_d, p1x_d, p1y_d, q1x_d, q1y_d;
  logic signed [CW-1:0] z0p, z0q, z1p, z1q;
  logic signed [CW-1:0] p0x_q, p0y_q, q0x_q, q0y_q, p1x_q, p1y_q, q1x_q, q1y_q;
  logic        [CW:0]   n0_q, d0_q, n1_q, d1_q;

  always_comb begin
    p0x_d = vertex_a_x_i; p0y_d = vertex_a_y_i; z0p = vertex_a_z_i;
    q0x_d = vertex_b_x_i; q0y_d = vertex_b_y_i; z0q = vertex_b_z_i;
    p1x_d = vertex_b_x_i; p1y_d = vertex_b_y_i; z1p = vertex_b_z_i;
    q1x_d = vertex_c_x_i; q1y_d = vertex_c_y_i; z1q = vertex_c_z_i;
    if (!x01) begin
      p0x_d = vertex_b_x_i; p0y_d = vertex_b_y_i; z0p = vertex_b_z_i;
      q0x_d = vertex_c_x_i; q0y_d = vertex_c_y_i; z0q = vertex_c_z_i;
    end
    if (!(x01 && x12)) begin
      p1x_d = vertex_c_x_i; p1y_d = vertex_c_y_i; z1p = vertex_c_z_i;
      q1x_d = vertex_a_x_i; q1y_d = vertex_a_y_i; z1q = vertex_a_z_i;
    end
  end

  function automatic logic [CW:0] absdiff(logic signed [CW-1:0] u,
                                          logic signed [CW-1:0] v);
    logic signed [CW:0] d;
    d = (CW+1)'(u) - (CW+1)'(v);
    return d[CW] ? (CW+1)'(-d) : (CW+1)'(d);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0x_q <= p0x_d; p0y_q <= p0y_d; q0x_q <= q0x_d; q0y_q <= q0y_d;
      p1x_q <= p1x_d; p1y_q <= p1y_d; q1x_q <= q1x_d; q1y_q <= q1y_d;
      n0_q <= absdiff(contour_level_i, z0p);
      d0_q <= absdiff(z0q, z0p);
      n1_q <= absdiff(contour_level_i, z1p);
      d1_q <= absdiff(z1q, z1p);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i && hit};
    end
  end
  assign out_valid_o = vld_q[LAT-1];

  tis_cross #(.CW(CW), .TB(FRAC_T_BITS)) u_cross0 (
    .clk_i, .en_i(en),
    .pa_x_i(p0x_q), .pa_y_i(p0y_q), .pb_x_i(q0x_q), .pb_y_i(q0y_q),
    .num_i(n0_q), .den_i(d0_q), .px_o(seg_start_x_o), .py_o(seg_start_y_o)
  );
  tis_cross #(.CW(CW), .TB(FRAC_T_BITS)) u_cross1 (
    .clk_i, .en_i(en),
    .pa_x_i(p1x_q), .pa_y_i(p1y_q), .pb_x_i(q1x_q), .pb_y_i(q1y_q),
    .num_i(n1_q), .den_i(d1_q), .px_o(seg_end_x_o), .py_o(seg_end_y_o)
  );
endmodule
